[sv/stable_record_sort_by_key_macros.svh]
// assertion macros for the stable record sorter
// used by the top level only, no other dependencies
`ifndef STABLE_RECORD_SORT_BY_KEY_MACROS_SVH
`define STABLE_RECORD_SORT_BY_KEY_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRSK_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srsk same-cycle check failed");

// next-cycle implication, checked out of reset
`define SRSK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srsk next-cycle check failed");

`endif

[sv/srsk_pkg.sv]
// shared types for the stable record sorter
// record layout, cell control group and controller states; no dependencies
package srsk_pkg;

    localparam int CodeW  = 16;
    localparam int QtyW   = 16;
    localparam int PriceW = 24;
    localparam int KeyW   = 16;
    localparam int WarrW  = 8;

    typedef struct packed {
        logic [CodeW-1:0]  item_code;
        logic [QtyW-1:0]   quantity;
        logic [PriceW-1:0] unit_price;
        logic [KeyW-1:0]   stock_count;
        logic [WarrW-1:0]  warranty_months;
    } record_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

endpackage

[sv/srsk_cell.sv]
// one cell of the insertion chain: holds a single record
// depends on srsk_pkg for the record and control types
module srsk_cell (
    input  logic                aclk,
    input  srsk_pkg::cell_ctl_t ctl,
    input  logic                occupied,
    input  srsk_pkg::record_t   new_rec,
    input  srsk_pkg::record_t   prev_rec,
    input  logic                prev_keep,
    input  srsk_pkg::record_t   next_rec,
    output logic                keep,
    output srsk_pkg::record_t   rec
);

    srsk_pkg::record_t rec_reg;
    srsk_pkg::record_t rec_next;

    // held record stays put when its key is not above the new one (stable order)
    always_comb begin
        keep = occupied && (rec_reg.stock_count <= new_rec.stock_count);
    end

    always_comb begin
        rec_next = rec_reg;
        if (ctl.insert) begin
            if (!keep) begin
                // first non-kept cell takes the new item, the rest shift up
                rec_next = prev_keep ? new_rec : prev_rec;
            end
        end else if (ctl.shift_out) begin
            rec_next = next_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

[sv/stable_record_sort_by_key.sv]
// Stable record sorter on stock count. Records enter one per cycle while the block is
// loading; each is placed in a chain of CAPACITY cells as it is accepted, after every held
// record with a key less than or equal to its own, so equal keys keep load order. An item
// with final_record set ends the list: s_ready drops and the held records leave one per
// cycle while m_ready is high, from the head cell (m_* ports), lowest stock count first,
// end_of_list on the last. No new list is taken in until the last record has left.
// Records beyond CAPACITY are dropped and every result of that list carries dropped_flag.
// Depends on srsk_pkg, srsk_cell and stable_record_sort_by_key_macros.svh.
`include "stable_record_sort_by_key_macros.svh"

module stable_record_sort_by_key #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_item_code,
    input  logic [15:0] s_quantity,
    input  logic [23:0] s_unit_price,
    input  logic [15:0] s_stock_count,
    input  logic [7:0]  s_warranty_months,
    input  logic        s_final_record,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_item_code,
    output logic [15:0] m_out_quantity,
    output logic [23:0] m_out_unit_price,
    output logic [15:0] m_out_stock_count,
    output logic [7:0]  m_out_warranty_months,
    output logic        m_dropped_flag,
    output logic        m_end_of_list
);

    localparam int FillW = $clog2(CAPACITY + 1);

    srsk_pkg::state_t    state_reg;
    srsk_pkg::state_t    state_next;
    logic [FillW-1:0]    fill_reg;
    logic [FillW-1:0]    fill_next;
    logic                overflow_reg;
    logic                overflow_next;

    logic                in_accept;
    logic                out_accept;
    logic                has_room;
    srsk_pkg::cell_ctl_t ctl;
    srsk_pkg::record_t   new_rec;
    srsk_pkg::record_t   chain_rec [CAPACITY];
    logic                chain_keep [CAPACITY];

    assign in_accept  = s_valid && s_ready;
    assign out_accept = m_valid && m_ready;
    assign has_room   = fill_reg < FillW'(CAPACITY);

    always_comb begin
        new_rec.item_code       = s_item_code;
        new_rec.quantity        = s_quantity;
        new_rec.unit_price      = s_unit_price;
        new_rec.stock_count     = s_stock_count;
        new_rec.warranty_months = s_warranty_months;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srsk_pkg::ST_LOAD: begin
                if (in_accept && s_final_record) begin
                    state_next = srsk_pkg::ST_EMIT;
                end
            end
            srsk_pkg::ST_EMIT: begin
                if (out_accept && (fill_reg == FillW'(1))) begin
                    state_next = srsk_pkg::ST_LOAD;
                end
            end
            default: state_next = srsk_pkg::ST_LOAD;
        endcase
    end

    // outputs and control
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        ctl           = '0;
        fill_next     = fill_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            srsk_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (in_accept) begin
                    if (has_room) begin
                        ctl.insert = 1'b1;
                        fill_next  = fill_reg + FillW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
            end
            srsk_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (out_accept) begin
                    ctl.shift_out = 1'b1;
                    fill_next     = fill_reg - FillW'(1);
                    if (fill_reg == FillW'(1)) begin
                        overflow_next = 1'b0;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srsk_pkg::ST_LOAD;
            fill_reg     <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            overflow_reg <= overflow_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        srsk_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .occupied  (FillW'(i) < fill_reg),
            .new_rec   (new_rec),
            .prev_rec  ((i == 0) ? new_rec : chain_rec[(i == 0) ? 0 : i - 1]),
            .prev_keep ((i == 0) ? 1'b1 : chain_keep[(i == 0) ? 0 : i - 1]),
            .next_rec  (chain_rec[(i == CAPACITY - 1) ? i : i + 1]),
            .keep      (chain_keep[i]),
            .rec       (chain_rec[i])
        );
    end

    // head cell doubles as the output register
    assign m_out_item_code       = chain_rec[0].item_code;
    assign m_out_quantity        = chain_rec[0].quantity;
    assign m_out_unit_price      = chain_rec[0].unit_price;
    assign m_out_stock_count     = chain_rec[0].stock_count;
    assign m_out_warranty_months = chain_rec[0].warranty_months;
    assign m_dropped_flag        = overflow_reg;
    assign m_end_of_list         = (fill_reg == FillW'(1));

    `SRSK_ASSERT_NOW(a_no_overlap, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `SRSK_ASSERT_NOW(a_emit_nonempty, aclk, aresetn, m_valid, fill_reg != '0)
    `SRSK_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FillW'(CAPACITY))
    `SRSK_ASSERT_NEXT(a_final_emits, aclk, aresetn, in_accept && s_final_record, m_valid)
    `SRSK_ASSERT_NEXT(a_last_reloads, aclk, aresetn, out_accept && m_end_of_list,
                      s_ready && (fill_reg == '0) && !overflow_reg)

endmodule
